FILE: rtl/pwli_pkg.sv
// Shared constants, widths, status codes and state encoding for the
// piecewise-linear integrator. No dependencies.
package pwli_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;

    localparam int XW      = 32;            // Q16.16 sample width
    localparam int DW      = XW + 1;        // difference of two samples
    localparam int MUL_W   = DW + 1;        // multiplier operand
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 80;            // exact running sum of full segments
    localparam int ACC_W   = 104;           // exact result before saturation
    localparam int NUM_W   = 97;            // d*d*df magnitude
    localparam int DEN_W   = DW + 1;        // 2*|dx|
    localparam int OUT_W   = 64;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W   = 32;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_LIMITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER      = 2'd2;

    typedef enum logic [15:0] {
        ST_LOAD = 16'h0001,
        ST_MUL  = 16'h0002,
        ST_ACC  = 16'h0004,
        ST_FIN  = 16'h0008,
        ST_SRD  = 16'h0010,
        ST_SCMP = 16'h0020,
        ST_FRD0 = 16'h0040,
        ST_FRD1 = 16'h0080,
        ST_FRD2 = 16'h0100,
        ST_M0   = 16'h0200,
        ST_M1   = 16'h0400,
        ST_NUM  = 16'h0800,
        ST_DIV  = 16'h1000,
        ST_PACC = 16'h2000,
        ST_SAT  = 16'h4000,
        ST_OUT  = 16'h8000
    } state_t;

endpackage

FILE: rtl/piecewise_linear_integrator_top.sv
// Top level of the piecewise-linear integrator: point store, running sum,
// limit search and partial-segment evaluation. Depends on pwli_pkg, pwli_div.
//
//  port group | dir | fields (lowest bit first)           | transfer when
//  s_*        | in  | tdata: x_value, f_value; tlast:      | s_tvalid & s_tready
//             |     |   last_point                         |
//  m_*        | out | tdata: integral; tuser: status       | m_tvalid & m_tready
//  cfg_*      | in  | index 0 use_limits, 1 lower, 2 upper | cfg_we
//
// Loading a point runs a multiply step, then an accumulate step in which the next
// point may be taken. After the last point, a whole-table result passes through
// FIN, SAT and OUT; with limits each limit costs a binary search (SRD and SCMP per
// memory probe), a segment read, the multiplies and the divider. Reset needs no
// clearing pass. A waiting result in the output register stalls the next result
// in OUT, and point intake with it.
module piecewise_linear_integrator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // x_value, f_value
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,   // integral
    output logic [pwli_pkg::STAT_W-1:0]         m_tuser,   // status
    input  logic                                cfg_we,
    input  logic [pwli_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pwli_pkg::CFG_W-1:0]          cfg_data
);

    localparam int XW     = pwli_pkg::XW;
    localparam int DW     = pwli_pkg::DW;
    localparam int IDX_W  = pwli_pkg::IDX_W;
    localparam int CNT_W  = pwli_pkg::CNT_W;
    localparam int MUL_W  = pwli_pkg::MUL_W;
    localparam int PROD_W = pwli_pkg::PROD_W;
    localparam int SUM_W  = pwli_pkg::SUM_W;
    localparam int ACC_W  = pwli_pkg::ACC_W;
    localparam int NUM_W  = pwli_pkg::NUM_W;
    localparam int OUT_W  = pwli_pkg::OUT_W;

    pwli_pkg::state_t state_reg, state_next;

    logic                          use_limits_reg;
    logic signed [XW-1:0]          lower_reg, upper_reg;

    logic [CNT_W-1:0]              count_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic                          zero_reg;
    logic signed [XW-1:0]          first_x_reg, prev_x_reg, prev_f_reg;
    logic                          pend_last_reg;
    logic [IDX_W-1:0]              pend_idx_reg;
    logic signed [DW-1:0]          dx_reg, df_reg, d_reg;
    logic signed [XW-1:0]          f0_reg, x0_reg, t_reg;
    logic                          sa_reg, sb_reg;
    logic [PROD_W-1:0]             prod_a_reg, prod_b_reg, lin_reg;
    logic [NUM_W-1:0]              num_reg;
    logic                          div_go_reg;
    logic [IDX_W-1:0]              lo_reg, hi_reg, mid_reg;
    logic                          asc_reg, lim_hi_reg;
    logic signed [SUM_W-1:0]       sj_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [OUT_W-1:0]              res_data_reg, m_data_reg;
    logic [pwli_pkg::STAT_W-1:0]   res_stat_reg, m_user_reg;
    logic                          m_valid_reg;

    logic [2*XW-1:0]               xf_mem [0:pwli_pkg::MAX_POINTS-1];
    logic signed [SUM_W-1:0]       sum_mem [0:pwli_pkg::MAX_POINTS-1];
    logic [2*XW-1:0]               rd_xf_reg;
    logic signed [SUM_W-1:0]       rd_sum_reg;
    logic [IDX_W-1:0]              rd_addr;
    logic                          sum_we;
    logic [IDX_W-1:0]              sum_waddr;
    logic signed [SUM_W-1:0]       sum_wdata;

    logic                          accept, stored, has_seg;
    logic signed [XW-1:0]          in_x, in_f, rd_x, rd_f;
    logic [IDX_W:0]                lohi;
    logic [IDX_W-1:0]              mid, last_idx;
    logic [DW-1:0]                 mag_dx, mag_df, mag_d;
    logic [XW-1:0]                 mag_f0;
    logic [MUL_W-1:0]              a1, a2, b1, b2;
    logic [PROD_W-1:0]             prod_a, prod_b;
    logic signed [SUM_W-1:0]       ext_a, ext_b, seg_full, sum_next;
    logic signed [ACC_W-1:0]       ext_lin, ext_q, part_val, acc_next;
    logic                          dx_zero, div_done;
    logic [NUM_W-1:0]              div_q, q_use;
    logic                          fits;

    assign in_x = s_tdata[XW-1:0];
    assign in_f = s_tdata[2*XW-1:XW];
    assign rd_x = rd_xf_reg[XW-1:0];
    assign rd_f = rd_xf_reg[2*XW-1:XW];

    assign s_tready = (state_reg == pwli_pkg::ST_LOAD)
                   || (state_reg == pwli_pkg::ST_ACC && !pend_last_reg);
    assign accept   = s_tvalid && s_tready;
    assign stored   = count_reg < CNT_W'(pwli_pkg::MAX_POINTS);
    assign has_seg  = count_reg != '0;

    assign lohi     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = lohi[IDX_W:1];
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    // Magnitudes for the unsigned multipliers.
    assign mag_dx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign mag_df = df_reg[DW-1] ? DW'(-df_reg) : DW'(df_reg);
    assign mag_d  = d_reg[DW-1]  ? DW'(-d_reg)  : DW'(d_reg);
    assign mag_f0 = f0_reg[XW-1] ? XW'(-f0_reg) : XW'(f0_reg);
    assign dx_zero = dx_reg == '0;

    always_comb
    begin
        a1 = {1'b0, mag_dx};
        a2 = {2'b00, mag_f0};
        b1 = {1'b0, mag_dx};
        b2 = {1'b0, mag_df};
        case (state_reg)
            pwli_pkg::ST_M0:
            begin
                a1 = {1'b0, mag_d};
                b1 = {1'b0, mag_d};
                b2 = {1'b0, mag_d};
            end
            pwli_pkg::ST_M1:
            begin
                // d*d split in two halves, each times |df|
                a1 = {2'b00, prod_b_reg[XW-1:0]};
                a2 = {1'b0, mag_df};
                b1 = prod_b_reg[XW+MUL_W-1:XW];
            end
            default: ;
        endcase
    end

    assign prod_a = a1 * a2;
    assign prod_b = b1 * b2;

    // Full segment: dx*f0 + dx*df/2 truncated toward zero.
    assign ext_a    = $signed({{(SUM_W-PROD_W){1'b0}}, prod_a_reg});
    assign ext_b    = $signed({{(SUM_W-PROD_W){1'b0}}, prod_b_reg >> 1});
    assign seg_full = (sa_reg ? -ext_a : ext_a) + (sb_reg ? -ext_b : ext_b);
    assign sum_next = sum_reg + seg_full;

    // Partial segment plus prefix sum of the segments before it.
    assign q_use    = dx_zero ? '0 : div_q;
    assign ext_lin  = $signed({{(ACC_W-PROD_W){1'b0}}, lin_reg});
    assign ext_q    = $signed({{(ACC_W-NUM_W){1'b0}}, q_use});
    assign part_val = ACC_W'(sj_reg)
                    + ((d_reg[DW-1] ^ f0_reg[XW-1]) ? -ext_lin : ext_lin)
                    + ((df_reg[DW-1] ^ dx_reg[DW-1]) ? -ext_q : ext_q);
    assign acc_next = lim_hi_reg ? acc_reg + part_val : acc_reg - part_val;

    assign fits = (&acc_reg[ACC_W-1:OUT_W-1]) || !(|acc_reg[ACC_W-1:OUT_W-1]);

    pwli_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (num_reg),
        .den   ({mag_dx, 1'b0}),
        .done  (div_done),
        .quot  (div_q)
    );

    // Point and prefix-sum memories.
    always_comb
    begin
        case (state_reg)
            pwli_pkg::ST_SRD:  rd_addr = mid;
            pwli_pkg::ST_FRD1: rd_addr = lo_reg + IDX_W'(1);
            default:           rd_addr = lo_reg;
        endcase
        sum_we    = 1'b0;
        sum_waddr = pend_idx_reg;
        sum_wdata = sum_next;
        if (state_reg == pwli_pkg::ST_ACC)
        begin
            sum_we = 1'b1;
        end
        else if (accept && !has_seg)
        begin
            sum_we    = 1'b1;
            sum_waddr = '0;
            sum_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && stored)
        begin
            xf_mem[count_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        rd_xf_reg  <= xf_mem[rd_addr];
        rd_sum_reg <= sum_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwli_pkg::ST_LOAD: ;
            pwli_pkg::ST_MUL:  state_next = pwli_pkg::ST_ACC;
            pwli_pkg::ST_ACC:  state_next = pend_last_reg ? pwli_pkg::ST_FIN : pwli_pkg::ST_LOAD;
            pwli_pkg::ST_FIN:
            begin
                if (count_reg < CNT_W'(2))
                    state_next = pwli_pkg::ST_OUT;
                else if (!use_limits_reg)
                    state_next = pwli_pkg::ST_SAT;
                else
                    state_next = pwli_pkg::ST_SRD;
            end
            pwli_pkg::ST_SRD:
                state_next = (hi_reg - lo_reg > IDX_W'(1)) ? pwli_pkg::ST_SCMP
                                                           : pwli_pkg::ST_FRD0;
            pwli_pkg::ST_SCMP: state_next = pwli_pkg::ST_SRD;
            pwli_pkg::ST_FRD0: state_next = pwli_pkg::ST_FRD1;
            pwli_pkg::ST_FRD1: state_next = pwli_pkg::ST_FRD2;
            pwli_pkg::ST_FRD2: state_next = pwli_pkg::ST_M0;
            pwli_pkg::ST_M0:   state_next = pwli_pkg::ST_M1;
            pwli_pkg::ST_M1:   state_next = pwli_pkg::ST_NUM;
            pwli_pkg::ST_NUM:  state_next = dx_zero ? pwli_pkg::ST_PACC : pwli_pkg::ST_DIV;
            pwli_pkg::ST_DIV:  state_next = div_done ? pwli_pkg::ST_PACC : pwli_pkg::ST_DIV;
            pwli_pkg::ST_PACC: state_next = lim_hi_reg ? pwli_pkg::ST_SAT : pwli_pkg::ST_SRD;
            pwli_pkg::ST_SAT:  state_next = pwli_pkg::ST_OUT;
            pwli_pkg::ST_OUT:
                state_next = (!m_valid_reg || m_tready) ? pwli_pkg::ST_LOAD : pwli_pkg::ST_OUT;
            default:           state_next = pwli_pkg::ST_LOAD;
        endcase
        if (accept)
        begin
            if (stored && has_seg)
                state_next = pwli_pkg::ST_MUL;
            else if (s_tlast)
                state_next = pwli_pkg::ST_FIN;
            else
                state_next = pwli_pkg::ST_LOAD;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pwli_pkg::ST_LOAD;
            use_limits_reg <= 1'b0;
            lower_reg      <= '0;
            upper_reg      <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            zero_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            div_go_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= (state_reg == pwli_pkg::ST_NUM) && !dx_zero;
            if (cfg_we)
            begin
                case (cfg_index)
                    pwli_pkg::CFG_USE_LIMITS: use_limits_reg <= cfg_data[0];
                    pwli_pkg::CFG_LOWER:      lower_reg      <= cfg_data;
                    pwli_pkg::CFG_UPPER:      upper_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == pwli_pkg::ST_ACC)
            begin
                sum_reg <= sum_next;
            end
            if (accept && stored)
            begin
                count_reg <= count_reg + CNT_W'(1);
                if (has_seg && in_x == prev_x_reg)
                begin
                    zero_reg <= 1'b1;
                end
            end
            if (state_reg == pwli_pkg::ST_OUT && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
                count_reg   <= '0;
                sum_reg     <= '0;
                zero_reg    <= 1'b0;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        if (accept && stored)
        begin
            prev_x_reg    <= in_x;
            prev_f_reg    <= in_f;
            pend_idx_reg  <= count_reg[IDX_W-1:0];
            pend_last_reg <= s_tlast;
            dx_reg        <= {in_x[XW-1], in_x} - {prev_x_reg[XW-1], prev_x_reg};
            df_reg        <= {in_f[XW-1], in_f} - {prev_f_reg[XW-1], prev_f_reg};
            f0_reg        <= prev_f_reg;
            if (!has_seg)
            begin
                first_x_reg <= in_x;
            end
        end
        case (state_reg)
            pwli_pkg::ST_MUL:
            begin
                prod_a_reg <= prod_a;
                prod_b_reg <= prod_b;
                sa_reg     <= dx_reg[DW-1] ^ f0_reg[XW-1];
                sb_reg     <= dx_reg[DW-1] ^ df_reg[DW-1];
            end
            pwli_pkg::ST_FIN:
            begin
                acc_reg    <= ACC_W'(sum_reg);
                asc_reg    <= prev_x_reg >= first_x_reg;
                lo_reg     <= '0;
                hi_reg     <= last_idx;
                t_reg      <= lower_reg;
                lim_hi_reg <= 1'b0;
                if (count_reg < CNT_W'(2))
                begin
                    res_data_reg <= '0;
                    res_stat_reg <= pwli_pkg::STAT_SHORT;
                end
                if (use_limits_reg)
                begin
                    acc_reg <= '0;
                end
            end
            pwli_pkg::ST_SRD:  mid_reg <= mid;
            pwli_pkg::ST_SCMP:
            begin
                if ((t_reg >= rd_x) == asc_reg)
                    lo_reg <= mid_reg;
                else
                    hi_reg <= mid_reg;
            end
            pwli_pkg::ST_FRD1:
            begin
                x0_reg <= rd_x;
                f0_reg <= rd_f;
                sj_reg <= rd_sum_reg;
            end
            pwli_pkg::ST_FRD2:
            begin
                dx_reg <= {rd_x[XW-1], rd_x} - {x0_reg[XW-1], x0_reg};
                df_reg <= {rd_f[XW-1], rd_f} - {f0_reg[XW-1], f0_reg};
                d_reg  <= {t_reg[XW-1], t_reg} - {x0_reg[XW-1], x0_reg};
            end
            pwli_pkg::ST_M0:
            begin
                prod_a_reg <= prod_a;
                prod_b_reg <= prod_b;
            end
            pwli_pkg::ST_M1:
            begin
                lin_reg    <= prod_a_reg;
                prod_a_reg <= prod_a;
                prod_b_reg <= prod_b;
            end
            pwli_pkg::ST_NUM:
                num_reg <= NUM_W'(prod_a_reg) + (NUM_W'(prod_b_reg) << XW);
            pwli_pkg::ST_PACC:
            begin
                acc_reg    <= acc_next;
                lim_hi_reg <= 1'b1;
                t_reg      <= upper_reg;
                lo_reg     <= '0;
                hi_reg     <= last_idx;
            end
            pwli_pkg::ST_SAT:
            begin
                if (fits)
                begin
                    res_data_reg <= acc_reg[OUT_W-1:0];
                    res_stat_reg <= zero_reg ? pwli_pkg::STAT_ZERO : pwli_pkg::STAT_OK;
                end
                else
                begin
                    res_data_reg <= acc_reg[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                     : {1'b0, {(OUT_W-1){1'b1}}};
                    res_stat_reg <= pwli_pkg::STAT_SAT;
                end
            end
            pwli_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_reg <= res_data_reg;
                    m_user_reg <= res_stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/pwli_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pwli_pkg for widths.
module pwli_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pwli_pkg::NUM_W-1:0]    num,
    input  logic [pwli_pkg::DEN_W-1:0]    den,
    output logic                          done,
    output logic [pwli_pkg::NUM_W-1:0]    quot
);

    localparam int STEP_W = $clog2(pwli_pkg::NUM_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [pwli_pkg::NUM_W-1:0]    work_reg;
    logic [pwli_pkg::DEN_W-1:0]    rem_reg;
    logic [pwli_pkg::DEN_W-1:0]    den_reg;
    logic [pwli_pkg::DEN_W:0]      trial;
    logic [pwli_pkg::DEN_W:0]      diff;
    logic                          fit;

    assign trial = {rem_reg, work_reg[pwli_pkg::NUM_W-1]};
    assign fit   = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(pwli_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out the top while quotient bits enter at the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fit ? diff[pwli_pkg::DEN_W-1:0] : trial[pwli_pkg::DEN_W-1:0];
            work_reg <= {work_reg[pwli_pkg::NUM_W-2:0], fit};
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

FILE: rtl/pwli_checker.sv
// Port-level checks for the piecewise-linear integrator, bound to the top.
// Depends on pwli_pkg for status codes.
module pwli_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [63:0]                       m_tdata,
    input logic [pwli_pkg::STAT_W-1:0]       m_tuser
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A table of fewer than two points integrates to zero.
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == pwli_pkg::STAT_SHORT |-> m_tdata == 64'd0)
        else $error("short table with nonzero integral");

    // Saturated results sit at one end of the range.
    a_sat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == pwli_pkg::STAT_SAT |->
            m_tdata == 64'h8000_0000_0000_0000 || m_tdata == 64'h7FFF_FFFF_FFFF_FFFF)
        else $error("saturated value not at range end");

    // The transfer that closes a table stops intake while the result is built.
    a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after last point");

endmodule

bind piecewise_linear_integrator_top pwli_checker u_pwli_checker (.*);

FILE: test/tb_piecewise_linear_integrator_top.sv
// Testbench for piecewise_linear_integrator_top: streams directed and random point tables,
// predicts each integral and status, checks every result transfer in order.
// Depends on pwli_pkg and the RTL of the integrator.
module tb_piecewise_linear_integrator_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 750;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] f;
        logic        last;
    } point_t;

    typedef struct packed {
        logic [63:0]                 integral;
        logic [pwli_pkg::STAT_W-1:0] status;
    } integral_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [63:0] m_tdata;
    logic [pwli_pkg::STAT_W-1:0] m_tuser;
    logic cfg_we;
    logic [pwli_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pwli_pkg::CFG_W-1:0] cfg_data;

    point_t    point_q[$];
    integral_t integral_q[$];

    // predictor state
    logic signed [31:0]  x_tab[pwli_pkg::MAX_POINTS];
    logic signed [31:0]  f_tab[pwli_pkg::MAX_POINTS];
    int                  n_points;
    logic signed [127:0] running_sum;
    logic                zero_width;
    logic                limits_on;
    logic signed [31:0]  lo_bound;
    logic signed [31:0]  hi_bound;

    int  src_idle_pct;
    int  snk_stall_pct;
    logic long_hold;
    logic hold_taken;
    int  hold_left;
    logic in_taken;
    int  errors;
    int  quiet_cycles;
    int  random_sent;

    piecewise_linear_integrator_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // integral of segment i from x[i] to t, in Q32.32
    function automatic logic signed [127:0] seg_part(int i, logic signed [63:0] t);
        logic signed [127:0] d, dx, df, f0, r;
        logic [127:0] dm, fm, xm, p;
        d  = t - x_tab[i];
        dx = x_tab[i+1] - x_tab[i];
        df = f_tab[i+1] - f_tab[i];
        f0 = f_tab[i];
        r  = d * f0;
        if (dx != 0)
        begin
            dm = (d < 0) ? -d : d;
            fm = (df < 0) ? -df : df;
            xm = (dx < 0) ? -dx : dx;
            p  = (dm * dm * fm) / (xm << 1);
            if ((df < 0) != (dx < 0))
                r = r - $signed(p);
            else
                r = r + $signed(p);
        end
        return r;
    endfunction

    function automatic logic signed [127:0] seg_full(int i);
        return seg_part(i, x_tab[i+1]);
    endfunction

    // binary search for the segment holding t, clamped to the end segments
    function automatic int find_segment(logic signed [63:0] t, int n);
        logic asc;
        int lo, hi, mid;
        asc = x_tab[n-1] >= x_tab[0];
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if ((t >= x_tab[mid]) == asc)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    task automatic take_point(point_t p);
        logic signed [127:0] r;
        int lp, hp;
        integral_t res;
        if (n_points < pwli_pkg::MAX_POINTS)
        begin
            x_tab[n_points] = p.x;
            f_tab[n_points] = p.f;
            if (n_points > 0)
            begin
                if (p.x == x_tab[n_points-1])
                    zero_width = 1'b1;
                running_sum = running_sum + seg_full(n_points - 1);
            end
            n_points++;
        end
        if (!p.last)
            return;
        if (n_points < 2)
        begin
            res.integral = '0;
            res.status = pwli_pkg::STAT_SHORT;
        end
        else
        begin
            r = running_sum;
            if (limits_on)
            begin
                lp = find_segment(lo_bound, n_points);
                hp = find_segment(hi_bound, n_points);
                for (int i = 0; i < lp; i++)
                    r = r - seg_full(i);
                r = r - seg_part(lp, lo_bound);
                r = r - seg_full(hp);
                r = r + seg_part(hp, hi_bound);
                for (int i = hp + 1; i < n_points - 1; i++)
                    r = r - seg_full(i);
            end
            res.status = zero_width ? pwli_pkg::STAT_ZERO : pwli_pkg::STAT_OK;
            if (&r[127:63] || ~|r[127:63])
                res.integral = r[63:0];
            else
            begin
                res.integral = r[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                res.status = pwli_pkg::STAT_SAT;
            end
        end
        integral_q = {integral_q, res};
        n_points = 0;
        running_sum = '0;
        zero_width = 1'b0;
    endtask

    // input side: drive at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (point_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
            begin
                point_t p;
                p = point_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {p.f, p.x};
                s_tlast <= p.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // output side: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (long_hold && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= 600;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= $urandom_range(99) >= snk_stall_pct;
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        in_taken = s_tvalid && s_tready && rst_n;
        if (in_taken)
            take_point('{x: s_tdata[31:0], f: s_tdata[63:32], last: s_tlast});
        if (m_tvalid && m_tready && rst_n)
        begin
            if (integral_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: integral %h status %0d", m_tdata, m_tuser);
            end
            else
            begin
                integral_t e;
                e = integral_q.pop_front();
                if (e.integral !== m_tdata || e.status !== m_tuser)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected integral %h status %0d, got %h status %0d",
                                 e.integral, e.status, m_tdata, m_tuser);
                end
            end
        end
        if (in_taken || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else if (rst_n)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [pwli_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == pwli_pkg::CFG_USE_LIMITS)
            limits_on = val[0];
        else if (idx == pwli_pkg::CFG_LOWER)
            lo_bound = val;
        else if (idx == pwli_pkg::CFG_UPPER)
            hi_bound = val;
    endtask

    task automatic push_point(logic [31:0] x, logic [31:0] f, logic last);
        point_t p;
        p = '{x: x, f: f, last: last};
        point_q = {point_q, p};
    endtask

    // kind 0 ascending, 1 descending, 2 fully random abscissas
    task automatic push_table(int n, int kind);
        logic signed [31:0] x, step;
        logic [31:0] f;
        logic wide_f;
        x = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
        wide_f = $urandom_range(3) == 0;
        for (int i = 0; i < n; i++)
        begin
            f = wide_f ? $urandom : $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
            if (kind == 2)
                x = $urandom;
            push_point(x, f, i == n - 1);
            step = $urandom_range(8) == 0 ? 0 : $urandom_range(32'h0004_0000, 1);
            x = (kind == 1) ? x - step : x + step;
        end
        random_sent += n;
    endtask

    task automatic drain;
        while (point_q.size() > 0 || s_tvalid || integral_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = pwli_pkg::CFG_USE_LIMITS;
        cfg_data = '0;
        n_points = 0;
        running_sum = '0;
        zero_width = 1'b0;
        limits_on = 1'b0;
        lo_bound = '0;
        hi_bound = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        long_hold = 1'b0;
        hold_taken = 1'b0;
        hold_left = 0;
        in_taken = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        random_sent = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: short tables, zero width, extremes, descending, saturation
        push_point(32'h0001_0000, 32'h0002_0000, 1'b1);
        push_point(32'h0000_0000, 32'h0001_0000, 1'b0);
        push_point(32'h0002_0000, 32'h0003_0000, 1'b1);
        push_point(32'h0001_0000, 32'h0001_0000, 1'b0);
        push_point(32'h0001_0000, 32'h0005_0000, 1'b0);
        push_point(32'h0003_0000, 32'hFFFE_0000, 1'b1);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        push_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        push_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_point(32'h8000_0000, 32'h8000_0000, 1'b1);
        push_point(32'h0005_0000, 32'h8000_0000, 1'b0);
        push_point(32'h0003_0000, 32'h7FFF_FFFF, 1'b0);
        push_point(32'hFFFF_0000, 32'h0000_0001, 1'b1);
        drain();
        write_reg(pwli_pkg::CFG_LOWER, 32'h0000_8000);
        write_reg(pwli_pkg::CFG_UPPER, 32'h0002_8000);
        write_reg(pwli_pkg::CFG_USE_LIMITS, 1'b1);
        push_point(32'h0000_0000, 32'h0001_0000, 1'b0);
        push_point(32'h0001_0000, 32'h0003_0000, 1'b0);
        push_point(32'h0002_0000, 32'hFFFF_0000, 1'b0);
        push_point(32'h0003_0000, 32'h0002_0000, 1'b1);
        push_point(32'h0003_0000, 32'h0001_0000, 1'b0);
        push_point(32'h0000_0000, 32'h0004_0000, 1'b1);
        push_point(32'h0000_0000, 32'h0004_0000, 1'b1);
        drain();

        random_sent = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
                default: begin src_idle_pct = 10; snk_stall_pct = 10; end
            endcase
            case (ph)
                0: write_reg(pwli_pkg::CFG_USE_LIMITS, 1'b0);
                1:
                begin
                    write_reg(pwli_pkg::CFG_LOWER, 32'h8000_0000);
                    write_reg(pwli_pkg::CFG_UPPER, 32'h7FFF_FFFF);
                    write_reg(pwli_pkg::CFG_USE_LIMITS, 1'b1);
                end
                2:
                begin
                    write_reg(pwli_pkg::CFG_LOWER, 32'h7FFF_FFFF);
                    write_reg(pwli_pkg::CFG_UPPER, 32'h8000_0000);
                end
                5:
                begin
                    write_reg(pwli_pkg::CFG_LOWER, $urandom);
                    write_reg(pwli_pkg::CFG_UPPER, $urandom);
                end
                default:
                begin
                    write_reg(pwli_pkg::CFG_LOWER,
                              $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
                    write_reg(pwli_pkg::CFG_UPPER,
                              $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
                    write_reg(pwli_pkg::CFG_USE_LIMITS, $urandom_range(3) != 0);
                end
            endcase
            if (ph == 2)
                long_hold = 1'b1;
            while (random_sent < (ph + 1) * RANDOM_ITEMS / 8)
                push_table($urandom_range(9) == 0 ? $urandom_range(40, 2) : $urandom_range(7, 1),
                           $urandom_range(2));
            drain();
        end

        if (integral_q.size() != 0)
            errors++;
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
